@@ src/stra_pkg.sv @@
// ----------------------------------------------------------------------------
// stra_pkg
// Shared types and constants of the sign trend rate adapter: word formats,
// per-entry state, pipeline stage contents and configuration register codes.
// ----------------------------------------------------------------------------
package stra_pkg;

	localparam int NUM_WEIGHTS = 1024;
	localparam int ADDR_W      = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

	localparam int INDEX_W  = 10;
	localparam int WEIGHT_W = 32;
	localparam int RATE_W   = 32;
	localparam int TREND_W  = 8;
	localparam int COEFF_W  = 16;
	localparam int PROD_W   = RATE_W + COEFF_W;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic signed [TREND_W-1:0] TREND_MAX = 8'sd127;
	localparam logic signed [TREND_W-1:0] TREND_MIN = -8'sd127;

	localparam logic [RATE_W-1:0]  START_RATE_RST   = 32'h0100_0000;
	localparam logic [RATE_W-1:0]  MIN_RATE_RST     = 32'h0000_0000;
	localparam logic [RATE_W-1:0]  MAX_RATE_RST     = 32'hFFFF_FFFF;
	localparam logic [COEFF_W-1:0] GROW_COEFF_RST   = 16'h0000;
	localparam logic [COEFF_W-1:0] SHRINK_COEFF_RST = 16'h0000;

	typedef enum logic {
		REQ_LOAD  = 1'b0,
		REQ_ADAPT = 1'b1
	} stra_kind_t;

	typedef enum logic [1:0] {
		SCALE_NONE,
		SCALE_GROW,
		SCALE_SHRINK
	} stra_scale_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_RATE,
		CFG_MIN_RATE,
		CFG_MAX_RATE,
		CFG_GROW_COEFF,
		CFG_SHRINK_COEFF
	} stra_cfg_idx_t;

	typedef struct packed {
		logic                       req_type;
		logic [INDEX_W-1:0]         elem_index;
		logic signed [WEIGHT_W-1:0] weight_value;
	} stra_req_t;

	typedef struct packed {
		logic [INDEX_W-1:0]        out_index;
		logic [RATE_W-1:0]         new_rate;
		logic signed [TREND_W-1:0] run_count;
	} stra_rsp_t;

	typedef struct packed {
		logic [RATE_W-1:0]  start_rate;
		logic [RATE_W-1:0]  min_rate;
		logic [RATE_W-1:0]  max_rate;
		logic [COEFF_W-1:0] grow_coeff;
		logic [COEFF_W-1:0] shrink_coeff;
	} stra_cfg_t;

	typedef struct packed {
		logic signed [WEIGHT_W-1:0] weight;
		logic signed [TREND_W-1:0]  trend;
		logic [RATE_W-1:0]          rate;
	} stra_entry_t;

	localparam int ENTRY_W = $bits(stra_entry_t);

	// Pending or just-written entry update, used for write-back and bypass
	typedef struct packed {
		logic               hit;
		logic [INDEX_W-1:0] idx;
		stra_entry_t        entry;
	} stra_fwd_t;

	typedef struct packed {
		logic               req_type;
		logic               in_range;
		logic [INDEX_W-1:0] idx;
		stra_entry_t        entry;
		stra_scale_t        scale;
		logic [COEFF_W-1:0] coeff;
	} stra_s2_t;

	typedef struct packed {
		logic               req_type;
		logic               in_range;
		logic [INDEX_W-1:0] idx;
		stra_entry_t        entry;
		stra_scale_t        scale;
		logic [PROD_W-1:0]  prod;
	} stra_s3_t;

endpackage

@@ src/stra_ram.sv @@
// ----------------------------------------------------------------------------
// stra_ram
// Generic single write port, single read port RAM with registered read data.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module stra_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/stra_cfg.sv @@
// ----------------------------------------------------------------------------
// stra_cfg
// Configuration register file: start rate, clamp bounds and the grow and
// shrink coefficients. Writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module stra_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [stra_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [stra_pkg::CFG_DATA_W-1:0]  cfg_data,
	output stra_pkg::stra_cfg_t              cfg
);
	import stra_pkg::*;

	stra_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_rate   <= START_RATE_RST;
			cfg_q.min_rate     <= MIN_RATE_RST;
			cfg_q.max_rate     <= MAX_RATE_RST;
			cfg_q.grow_coeff   <= GROW_COEFF_RST;
			cfg_q.shrink_coeff <= SHRINK_COEFF_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (stra_cfg_idx_t'(cfg_index))
				CFG_START_RATE: begin
					cfg_q.start_rate <= cfg_data[RATE_W-1:0];
				end
				CFG_MIN_RATE: begin
					cfg_q.min_rate <= cfg_data[RATE_W-1:0];
				end
				CFG_MAX_RATE: begin
					cfg_q.max_rate <= cfg_data[RATE_W-1:0];
				end
				CFG_GROW_COEFF: begin
					cfg_q.grow_coeff <= cfg_data[COEFF_W-1:0];
				end
				CFG_SHRINK_COEFF: begin
					cfg_q.shrink_coeff <= cfg_data[COEFF_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

@@ src/stra_trend.sv @@
// ----------------------------------------------------------------------------
// stra_trend
// Stage one: pick the freshest copy of the entry, compare weights, update
// the run counter and choose grow, shrink or no scaling. Registers stage two.
// ----------------------------------------------------------------------------
module stra_trend (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  valid_s1,
	input  stra_pkg::stra_req_t   req_s1,
	input  stra_pkg::stra_entry_t rd_entry,
	input  stra_pkg::stra_fwd_t   fwd_s3,
	input  stra_pkg::stra_fwd_t   fwd_wb,
	input  stra_pkg::stra_cfg_t   cfg,
	output logic                  valid_s2,
	output stra_pkg::stra_s2_t    s2
);
	import stra_pkg::*;

	stra_entry_t               cur;
	logic                      in_range;
	logic signed [TREND_W-1:0] new_trend;
	stra_scale_t               scale;
	stra_s2_t                  nxt;

	assign in_range = (32'(req_s1.elem_index) < NUM_WEIGHTS);

	// Newer pending update wins over the last write, which wins over the RAM
	always_comb begin
		cur = rd_entry;
		if (fwd_s3.hit && (fwd_s3.idx == req_s1.elem_index)) begin
			cur = fwd_s3.entry;
		end else if (fwd_wb.hit && (fwd_wb.idx == req_s1.elem_index)) begin
			cur = fwd_wb.entry;
		end
	end

	always_comb begin
		if (req_s1.weight_value > cur.weight) begin
			new_trend = (cur.trend > 8'sd0)
				? ((cur.trend < TREND_MAX) ? cur.trend + 8'sd1 : TREND_MAX)
				: 8'sd1;
		end else if (req_s1.weight_value < cur.weight) begin
			new_trend = (cur.trend < 8'sd0)
				? ((cur.trend > TREND_MIN) ? cur.trend - 8'sd1 : TREND_MIN)
				: -8'sd1;
		end else begin
			new_trend = 8'sd0;
		end
	end

	always_comb begin
		if (((cur.trend > 8'sd0) && (new_trend > 8'sd0)) ||
		    ((cur.trend < 8'sd0) && (new_trend < 8'sd0))) begin
			scale = SCALE_GROW;
		end else if (((cur.trend > 8'sd0) && (new_trend < 8'sd0)) ||
		             ((cur.trend < 8'sd0) && (new_trend > 8'sd0))) begin
			scale = SCALE_SHRINK;
		end else begin
			scale = SCALE_NONE;
		end
	end

	always_comb begin
		nxt.req_type     = req_s1.req_type;
		nxt.in_range     = in_range;
		nxt.idx          = req_s1.elem_index;
		nxt.entry.weight = req_s1.weight_value;
		if (req_s1.req_type == REQ_ADAPT) begin
			nxt.entry.trend = new_trend;
			nxt.entry.rate  = cur.rate;
			nxt.scale       = scale;
		end else begin
			nxt.entry.trend = 8'sd0;
			nxt.entry.rate  = cfg.start_rate;
			nxt.scale       = SCALE_NONE;
		end
		case (nxt.scale)
			SCALE_GROW:   nxt.coeff = cfg.grow_coeff;
			SCALE_SHRINK: nxt.coeff = cfg.shrink_coeff;
			default:      nxt.coeff = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			s2 <= nxt;
		end
	end

endmodule

@@ src/stra_rate.sv @@
// ----------------------------------------------------------------------------
// stra_rate
// Stage two multiplies the rate by the chosen coefficient; stage three adds
// or subtracts the scaled term, saturates, clamps and forms the result word.
// ----------------------------------------------------------------------------
module stra_rate (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                valid_s2,
	input  stra_pkg::stra_s2_t  s2,
	input  stra_pkg::stra_cfg_t cfg,
	output logic                valid_s3,
	output stra_pkg::stra_rsp_t res,
	output stra_pkg::stra_fwd_t wr
);
	import stra_pkg::*;

	logic [PROD_W-1:0] prod_c;
	stra_s3_t          s3;
	logic [RATE_W-1:0] term;
	logic [RATE_W:0]   sum;
	logic [RATE_W-1:0] grown;
	logic [RATE_W-1:0] shrunk;
	logic [RATE_W-1:0] scaled;
	logic [RATE_W-1:0] clamped;
	logic [RATE_W-1:0] final_rate;

	assign prod_c = PROD_W'(s2.entry.rate) * PROD_W'(s2.coeff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			s3.req_type <= s2.req_type;
			s3.in_range <= s2.in_range;
			s3.idx      <= s2.idx;
			s3.entry    <= s2.entry;
			s3.scale    <= s2.scale;
			s3.prod     <= prod_c;
		end
	end

	// Floor of rate*coeff in Q8.24
	assign term   = s3.prod[PROD_W-1:COEFF_W];
	assign sum    = {1'b0, s3.entry.rate} + {1'b0, term};
	assign grown  = sum[RATE_W] ? '1 : sum[RATE_W-1:0];
	// coeff is below one, so this cannot wrap
	assign shrunk = s3.entry.rate - term;

	always_comb begin
		case (s3.scale)
			SCALE_GROW:   scaled = grown;
			SCALE_SHRINK: scaled = shrunk;
			default:      scaled = s3.entry.rate;
		endcase
	end

	// Lower bound first: with inverted bounds, a rate below min_rate gives min_rate, any other max_rate
	always_comb begin
		if (scaled < cfg.min_rate) begin
			clamped = cfg.min_rate;
		end else if (scaled > cfg.max_rate) begin
			clamped = cfg.max_rate;
		end else begin
			clamped = scaled;
		end
	end

	assign final_rate = (s3.req_type == REQ_LOAD) ? s3.entry.rate : clamped;

	always_comb begin
		res.out_index = s3.idx;
		res.new_rate  = s3.in_range ? final_rate : '0;
		res.run_count = s3.in_range ? s3.entry.trend : '0;

		wr.hit          = valid_s3 && s3.in_range;
		wr.idx          = s3.idx;
		wr.entry.weight = s3.entry.weight;
		wr.entry.trend  = s3.entry.trend;
		wr.entry.rate   = final_rate;
	end

endmodule

@@ src/sign_trend_rate_adapter_top.sv @@
// ----------------------------------------------------------------------------
// sign_trend_rate_adapter_top
// Per-weight learning rate adaptation from the sign of each weight's moves.
// ----------------------------------------------------------------------------
// Takes one request word per cycle while req_stall is low and returns one result
// word per request, in order, from the result register behind stage three.
// A load word sets the entry's weight, clears its run counter and sets its
// rate to start_rate; an adapt word updates the run counter from the weight's
// direction and grows, shrinks and clamps the rate. Per-entry state lives in
// one RAM of NUM_WEIGHTS entries that is not cleared after reset, so an entry
// must be loaded before it is adapted. An adapt word that directly follows a
// word for the same entry is held while that word is in stage one, as its rate
// operand comes out of the multiply, add and clamp path of the word ahead in
// stages two and three; other sequences run at one word per cycle unless the
// result side stalls. Write the configuration only while no word is in flight.
module sign_trend_rate_adapter_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  stra_pkg::stra_req_t             req_word,
	output logic                            rsp_valid,
	input  logic                            rsp_stall,
	output stra_pkg::stra_rsp_t             rsp_word,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [stra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [stra_pkg::CFG_DATA_W-1:0] cfg_data
);
	import stra_pkg::*;

	stra_cfg_t          cfg;
	logic               adv;
	logic               hazard;
	logic               req_accept;
	logic               valid_s1;
	stra_req_t          req_s1;
	logic [ENTRY_W-1:0] rd_data;
	logic               valid_s2;
	stra_s2_t           s2;
	logic               valid_s3;
	stra_rsp_t          res;
	stra_fwd_t          wr;
	stra_fwd_t          fwd_wb;
	logic               wb_hit_q;
	logic [INDEX_W-1:0] wb_idx_q;
	stra_entry_t        wb_entry_q;
	logic               rsp_valid_q;
	stra_rsp_t          rsp_word_q;

	stra_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Whole pipeline advances together; hold everything while the output waits
	assign adv = !rsp_valid_q || !rsp_stall;

	assign hazard = req_valid && (req_word.req_type == REQ_ADAPT) && valid_s1 &&
		(req_s1.elem_index == req_word.elem_index);

	assign req_stall  = !adv || hazard;
	assign req_accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_accept;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_s1 <= req_word;
		end
	end

	stra_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_WEIGHTS)
	) u_state_ram (
		.clk   (clk),
		.we    (adv && wr.hit),
		.waddr (wr.idx[ADDR_W-1:0]),
		.wdata (wr.entry),
		.re    (req_accept),
		.raddr (req_word.elem_index[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	// Keep the last write: the RAM returns old data when read on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_hit_q <= 1'b0;
		end else if (adv && wr.hit) begin
			wb_hit_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && wr.hit) begin
			wb_idx_q   <= wr.idx;
			wb_entry_q <= wr.entry;
		end
	end

	assign fwd_wb = '{hit: wb_hit_q, idx: wb_idx_q, entry: wb_entry_q};

	stra_trend u_trend (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1),
		.rd_entry (stra_entry_t'(rd_data)),
		.fwd_s3   (wr),
		.fwd_wb   (fwd_wb),
		.cfg      (cfg),
		.valid_s2 (valid_s2),
		.s2       (s2)
	);

	stra_rate u_rate (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.valid_s2 (valid_s2),
		.s2       (s2),
		.cfg      (cfg),
		.valid_s3 (valid_s3),
		.res      (res),
		.wr       (wr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s3) begin
			rsp_word_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

endmodule

@@ src/stra_checker.sv @@
// ----------------------------------------------------------------------------
// stra_checker
// Port-level checks of the sign trend rate adapter, bound to the top level.
// ----------------------------------------------------------------------------
module stra_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input stra_pkg::stra_rsp_t rsp_word
);
	import stra_pkg::*;

	logic       req_acc;
	logic       rsp_acc;
	logic [2:0] inflight_q;

	assign req_acc = req_valid && !req_stall;
	assign rsp_acc = rsp_valid && !rsp_stall;

	// Count words accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 3'd0;
		end else begin
			case ({req_acc, rsp_acc})
				2'b10:   inflight_q <= inflight_q + 3'd1;
				2'b01:   inflight_q <= inflight_q - 3'd1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("result word changed while stalled");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while the result side is blocked");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> inflight_q != 3'd0)
		else $error("result word without a pending request");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd4)
		else $error("more words in flight than pipeline stages");

	a_run_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_word.run_count != 8'sh80)
		else $error("run counter outside its saturation range");

endmodule

bind sign_trend_rate_adapter_top stra_checker u_stra_checker (.*);

@@ dv/sign_trend_rate_adapter_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sign_trend_rate_adapter_top_test
// Self-checking bench for the per-weight sign trend rate adapter.
// ----------------------------------------------------------------------------
// Drives load and adapt words through the request channel with random gaps,
// stalls the result channel at random and checks every result word against
// an in-bench predictor of the run counter, the grow and shrink scaling and
// the rate clamp. Directed tests cover the field extremes, rate saturation,
// unclamped loads, inverted clamp bounds and run counter saturation; random
// phases then reprogram the registers and exercise a pool of entries.
// ----------------------------------------------------------------------------
module sign_trend_rate_adapter_top_test;

	import stra_pkg::*;

	localparam int QUIET_LIMIT = 2000;

	logic                  clk;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_stall;
	stra_req_t             req_word;
	logic                  rsp_valid;
	logic                  rsp_stall;
	stra_rsp_t             rsp_word;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Predictor copy of the registers and of the per-entry state
	stra_cfg_t                  shadow_cfg;
	logic signed [WEIGHT_W-1:0] last_weight [NUM_WEIGHTS];
	logic signed [TREND_W-1:0]  run_ctr     [NUM_WEIGHTS];
	logic [RATE_W-1:0]          cur_rate    [NUM_WEIGHTS];
	bit                         loaded      [NUM_WEIGHTS];

	stra_rsp_t pending_rsp [$];
	int        err_count;
	int        req_calm;
	int        rsp_calm;

	sign_trend_rate_adapter_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] exp_v,
			input logic [31:0] got_v);
		$display("MISMATCH %s: expected 0x%08h, got 0x%08h at %0t", what, exp_v, got_v,
			$realtime);
		err_count++;
	endtask

	// Work out the result of one accepted word and advance the entry state
	function automatic stra_rsp_t predict_rate(input stra_req_t w);
		stra_rsp_t                 r;
		logic signed [TREND_W-1:0] prev_run;
		logic signed [TREND_W-1:0] next_run;
		logic [RATE_W-1:0]         rate;
		logic [PROD_W-1:0]         prod;
		logic [RATE_W:0]           sum;
		r.out_index = w.elem_index;
		r.new_rate  = '0;
		r.run_count = '0;
		if (w.elem_index >= NUM_WEIGHTS)
			return r;
		if (w.req_type == REQ_LOAD) begin
			last_weight[w.elem_index] = w.weight_value;
			run_ctr[w.elem_index]     = '0;
			cur_rate[w.elem_index]    = shadow_cfg.start_rate;
			loaded[w.elem_index]      = 1'b1;
			r.new_rate                = shadow_cfg.start_rate;
			return r;
		end
		prev_run = run_ctr[w.elem_index];
		if (w.weight_value > last_weight[w.elem_index])
			next_run = (prev_run > 0) ? ((prev_run < TREND_MAX) ? prev_run + 8'sd1 : TREND_MAX)
				: 8'sd1;
		else if (w.weight_value < last_weight[w.elem_index])
			next_run = (prev_run < 0) ? ((prev_run > TREND_MIN) ? prev_run - 8'sd1 : TREND_MIN)
				: -8'sd1;
		else
			next_run = '0;
		rate = cur_rate[w.elem_index];
		if ((prev_run > 0 && next_run > 0) || (prev_run < 0 && next_run < 0)) begin
			prod = PROD_W'(rate) * PROD_W'(shadow_cfg.grow_coeff);
			sum  = (RATE_W+1)'(rate) + (RATE_W+1)'(prod >> COEFF_W);
			rate = sum[RATE_W] ? '1 : sum[RATE_W-1:0];
		end else if ((prev_run > 0 && next_run < 0) || (prev_run < 0 && next_run > 0)) begin
			prod = PROD_W'(rate) * PROD_W'(shadow_cfg.shrink_coeff);
			rate = rate - RATE_W'(prod >> COEFF_W);
		end
		// lower bound first: with inverted bounds, below min_rate gives min_rate, else max_rate
		if (rate < shadow_cfg.min_rate)
			rate = shadow_cfg.min_rate;
		else if (rate > shadow_cfg.max_rate)
			rate = shadow_cfg.max_rate;
		cur_rate[w.elem_index]    = rate;
		run_ctr[w.elem_index]     = next_run;
		last_weight[w.elem_index] = w.weight_value;
		r.new_rate  = rate;
		r.run_count = next_run;
		return r;
	endfunction

	// Send one request word; called and left at a falling edge
	task automatic send_word(input stra_kind_t kind, input logic [INDEX_W-1:0] idx,
			input logic [WEIGHT_W-1:0] weight);
		int        gap;
		stra_req_t w;
		if (req_calm > 0) begin
			req_calm--;
			gap = 0;
		end else begin
			if ($urandom_range(0, 9) == 0)
				req_calm = $urandom_range(10, 30);
			gap = $urandom_range(0, 15);
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		w.req_type     = kind;
		w.elem_index   = idx;
		w.weight_value = weight;
		req_valid <= 1'b1;
		req_word  <= w;
		do @(posedge clk); while (req_stall);
		pending_rsp.push_back(predict_rate(w));
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected word is back
	task automatic settle();
		req_valid <= 1'b0;
		while (pending_rsp.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic put_reg(input stra_cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_START_RATE:   shadow_cfg.start_rate   = data;
			CFG_MIN_RATE:     shadow_cfg.min_rate     = data;
			CFG_MAX_RATE:     shadow_cfg.max_rate     = data;
			CFG_GROW_COEFF:   shadow_cfg.grow_coeff   = data[COEFF_W-1:0];
			CFG_SHRINK_COEFF: shadow_cfg.shrink_coeff = data[COEFF_W-1:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic write_config(input stra_cfg_t c);
		settle();
		put_reg(CFG_START_RATE, c.start_rate);
		put_reg(CFG_MIN_RATE, c.min_rate);
		put_reg(CFG_MAX_RATE, c.max_rate);
		// upper bits of the coefficient words are don't-care; randomise them
		put_reg(CFG_GROW_COEFF, {16'($urandom()), c.grow_coeff});
		put_reg(CFG_SHRINK_COEFF, {16'($urandom()), c.shrink_coeff});
		cfg_valid <= 1'b0;
	endtask

	function automatic stra_cfg_t draw_config();
		stra_cfg_t c;
		c.start_rate   = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
			: $urandom_range(32'h0010_0000, 32'h0400_0000);
		c.min_rate     = ($urandom_range(0, 3) == 0) ? '0 : $urandom_range(0, 32'h0100_0000);
		c.max_rate     = ($urandom_range(0, 3) == 0) ? '1
			: $urandom_range(32'h0100_0000, 32'hF000_0000);
		c.grow_coeff   = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
			: 16'($urandom());
		c.shrink_coeff = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? '1 : '0)
			: 16'($urandom());
		return c;
	endfunction

	task automatic test_directed_adapt();
		write_config('{start_rate: 32'h0100_0000, min_rate: 32'h0010_0000,
			max_rate: 32'h0400_0000, grow_coeff: 16'h8000, shrink_coeff: 16'h4000});
		send_word(REQ_LOAD,  10'd0, 32'sd0);
		send_word(REQ_ADAPT, 10'd0, 32'sd1);
		send_word(REQ_ADAPT, 10'd0, 32'sd5);
		send_word(REQ_ADAPT, 10'd0, -32'sd3);
		send_word(REQ_ADAPT, 10'd0, -32'sd4);
		send_word(REQ_ADAPT, 10'd0, -32'sd4);
		send_word(REQ_LOAD,  10'h3FF, 32'h8000_0000);
		send_word(REQ_ADAPT, 10'h3FF, 32'h7FFF_FFFF);
		send_word(REQ_ADAPT, 10'h3FF, 32'h8000_0000);
		send_word(REQ_LOAD,  10'h155, 32'h5555_5555);
		send_word(REQ_LOAD,  10'h2AA, 32'hAAAA_AAAA);
		send_word(REQ_ADAPT, 10'h155, 32'h5555_5556);
		send_word(REQ_ADAPT, 10'h2AA, 32'hAAAA_AAAB);
	endtask

	task automatic test_rate_limits();
		// growth saturates at all ones, full shrink takes nearly everything
		write_config('{start_rate: 32'hFFFF_FFFF, min_rate: 32'h0, max_rate: 32'hFFFF_FFFF,
			grow_coeff: 16'hFFFF, shrink_coeff: 16'hFFFF});
		send_word(REQ_LOAD,  10'd5, 32'sd0);
		send_word(REQ_ADAPT, 10'd5, 32'sd1);
		send_word(REQ_ADAPT, 10'd5, 32'sd2);
		send_word(REQ_ADAPT, 10'd5, 32'sd1);
		send_word(REQ_ADAPT, 10'd5, 32'sd0);
		// loaded rate lies outside the bounds and is kept until the first adapt
		write_config('{start_rate: 32'h0000_0010, min_rate: 32'h0000_0100,
			max_rate: 32'h0000_1000, grow_coeff: 16'h0001, shrink_coeff: 16'h8000});
		send_word(REQ_LOAD,  10'd7, 32'sd100);
		send_word(REQ_ADAPT, 10'd7, 32'sd100);
		send_word(REQ_ADAPT, 10'd7, 32'sd200);
		send_word(REQ_ADAPT, 10'd7, 32'sd300);
		send_word(REQ_ADAPT, 10'd7, 32'sd250);
	endtask

	task automatic test_inverted_bounds();
		write_config('{start_rate: 32'h0300_0000, min_rate: 32'h0200_0000,
			max_rate: 32'h0100_0000, grow_coeff: 16'h4000, shrink_coeff: 16'h4000});
		send_word(REQ_LOAD,  10'd8, -32'sd10);
		send_word(REQ_ADAPT, 10'd8, -32'sd9);
		send_word(REQ_ADAPT, 10'd8, -32'sd8);
		send_word(REQ_ADAPT, 10'd8, -32'sd8);
	endtask

	// Long monotonic runs push the counter into both saturation limits
	task automatic test_run_saturation();
		logic [INDEX_W-1:0]         idx;
		logic signed [WEIGHT_W-1:0] w;
		write_config(draw_config());
		idx = INDEX_W'($urandom_range(0, NUM_WEIGHTS - 1));
		w   = -32'sh4000_0000;
		send_word(REQ_LOAD, idx, w);
		repeat (131) begin
			w = w + $urandom_range(1, 32'h000F_FFFF);
			send_word(REQ_ADAPT, idx, w);
		end
		repeat (131) begin
			w = w - $urandom_range(1, 32'h000F_FFFF);
			send_word(REQ_ADAPT, idx, w);
		end
	endtask

	task automatic test_random_phases();
		logic [INDEX_W-1:0]         pool [8];
		logic [INDEX_W-1:0]         idx;
		logic signed [WEIGHT_W-1:0] w;
		repeat (4) begin
			write_config(draw_config());
			foreach (pool[k])
				pool[k] = INDEX_W'($urandom_range(0, NUM_WEIGHTS - 1));
			repeat (45) begin
				idx = pool[3'($urandom_range(0, 7))];
				if (!loaded[idx] || $urandom_range(0, 11) == 0) begin
					send_word(REQ_LOAD, idx, $urandom());
				end else begin
					case ($urandom_range(0, 9))
						0, 1, 2, 3: w = last_weight[idx] + $urandom_range(1, 32'h0001_0000);
						4, 5, 6, 7: w = last_weight[idx] - $urandom_range(1, 32'h0001_0000);
						8:          w = last_weight[idx];
						default:    w = $urandom();
					endcase
					send_word(REQ_ADAPT, idx, w);
				end
			end
		end
	endtask

	// Result side: stall at random, then compare each word with the oldest expectation
	initial begin
		int        hold;
		stra_rsp_t exp_rsp;
		rsp_stall = 1'b0;
		rsp_calm  = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (rsp_calm > 0) begin
				rsp_calm--;
				hold = 0;
			end else begin
				if ($urandom_range(0, 9) == 0)
					rsp_calm = $urandom_range(10, 30);
				hold = $urandom_range(0, 15);
			end
			if (hold > 0) begin
				rsp_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			if (pending_rsp.size() == 0) begin
				report_mismatch("unexpected word, out_index", '0, 32'(rsp_word.out_index));
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp_word.out_index !== exp_rsp.out_index)
					report_mismatch("out_index", 32'(exp_rsp.out_index),
						32'(rsp_word.out_index));
				if (rsp_word.new_rate !== exp_rsp.new_rate)
					report_mismatch("new_rate", exp_rsp.new_rate, rsp_word.new_rate);
				if (rsp_word.run_count !== exp_rsp.run_count)
					report_mismatch("run_count", 32'(exp_rsp.run_count),
						32'(rsp_word.run_count));
			end
			@(negedge clk);
		end
	end

	// End the run when no word moves on any channel for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
					|| (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		req_valid  = 1'b0;
		req_word   = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		err_count  = 0;
		req_calm   = 0;
		shadow_cfg = '{start_rate: START_RATE_RST, min_rate: MIN_RATE_RST,
			max_rate: MAX_RATE_RST, grow_coeff: GROW_COEFF_RST,
			shrink_coeff: SHRINK_COEFF_RST};
		foreach (loaded[i])
			loaded[i] = 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_adapt();
		test_rate_limits();
		test_inverted_bounds();
		test_run_saturation();
		test_random_phases();

		settle();
		repeat (20) @(negedge clk);
		if (err_count == 0 && pending_rsp.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
